FILE: hw/rtl/askf_pkg.sv
// Shared widths, register indexes and reset values of the adaptive scalar Kalman filter.
`default_nettype none
package askf_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int R_W         = 24;
    localparam int Q_W         = 16;
    localparam int THR_W       = 23;
    localparam int RUN_W       = 8;
    localparam int LIMIT_W     = 13;
    localparam int FILTERED_W  = 13;
    localparam int EST_W       = 32;   // estimate, covariance, kept quotient bits
    localparam int WIDE_W      = 34;   // p_mid, denominator, deviation
    localparam int PROD_W      = 64;   // products and dividends, wrap modulo 2^64

    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_R_STEADY = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_Q_STEADY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_R_FAST   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_Q_FAST   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_JUMP_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_COUNT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LIMIT   = 3'd6;

    localparam logic [R_W-1:0]     RST_NOISE_R_STEADY = 24'd131072;
    localparam logic [Q_W-1:0]     RST_NOISE_Q_STEADY = 16'd4;
    localparam logic [R_W-1:0]     RST_NOISE_R_FAST   = 24'd512;
    localparam logic [Q_W-1:0]     RST_NOISE_Q_FAST   = 16'd128;
    localparam logic [THR_W-1:0]   RST_JUMP_THRESHOLD = 23'd32768;
    localparam logic [RUN_W-1:0]   RST_SWITCH_COUNT   = 8'd10;
    localparam logic [LIMIT_W-1:0] RST_OUTPUT_LIMIT   = 13'd4096;

endpackage
`default_nettype wire

FILE: hw/rtl/askf_in_if.sv
// Sample channel: valid/ready handshake carrying one raw converter sample.
`default_nettype none
interface askf_in_if #(
    parameter int SAMPLE_BITS = 12
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/askf_out_if.sv
// Result channel: valid/ready handshake carrying the filtered sample and reload flag.
`default_nettype none
interface askf_out_if ();
    import askf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FILTERED_W-1:0] filtered;
    logic                  reloaded;

    modport source (output valid, output filtered, output reloaded, input ready);
    modport sink   (input valid, input filtered, input reloaded, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/askf_mul.sv
// Shared multiplier: 64-bit wrapping product from one 32x32 multiplier.
`default_nettype none
module askf_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [askf_pkg::PROD_W-1:0] a,
    input  wire logic [askf_pkg::PROD_W-1:0] b,
    output logic                             done,
    output logic [askf_pkg::PROD_W-1:0]      product
);
    import askf_pkg::*;

    localparam int HALF = PROD_W / 2;

    logic              busy_reg;
    logic [1:0]        step_reg;
    logic              done_reg;
    logic [PROD_W-1:0] a_reg;
    logic [PROD_W-1:0] b_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [HALF-1:0]   op_x;
    logic [HALF-1:0]   op_y;

    // hi*hi term falls off the top of a 64-bit result; cross terms keep low halves only
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_x = a_reg[HALF-1:0];
                op_y = b_reg[HALF-1:0];
            end
            2'd1:
            begin
                op_x = a_reg[HALF-1:0];
                op_y = b_reg[PROD_W-1:HALF];
            end
            default:
            begin
                op_x = a_reg[PROD_W-1:HALF];
                op_y = b_reg[HALF-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            prod_reg <= PROD_W'(op_x) * PROD_W'(op_y);
            if (step_reg == 2'd1)
                acc_reg <= prod_reg;
            else if (step_reg != 2'd0)
                acc_reg[PROD_W-1:HALF] <= acc_reg[PROD_W-1:HALF] + prod_reg[HALF-1:0];
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/askf_div.sv
// Shared signed divider: 64 by 34 bits, truncating, two quotient bits per cycle.
`default_nettype none
module askf_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [askf_pkg::PROD_W-1:0] dividend,
    input  wire logic [askf_pkg::WIDE_W-1:0] divisor,
    output logic                             done,
    output logic [askf_pkg::EST_W-1:0]       quotient
);
    import askf_pkg::*;

    localparam int BITS_PER_STEP = 2;
    localparam int STEPS         = PROD_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(STEPS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]     num_reg;
    logic [WIDE_W-1:0]     dvs_reg;
    logic [WIDE_W-1:0]     rem_reg;
    logic [EST_W-1:0]      quo_reg;
    logic                  neg_reg;
    logic                  zero_reg;
    logic [EST_W-1:0]      quot_out_reg;

    logic [PROD_W-1:0]     num_v;
    logic [WIDE_W-1:0]     rem_v;
    logic [EST_W-1:0]      quo_v;

    // restoring steps; only the low 32 quotient bits survive the later wrap
    always_comb
    begin
        logic [WIDE_W:0] trial;
        num_v = num_reg;
        rem_v = rem_reg;
        quo_v = quo_reg;
        for (int i = 0; i < BITS_PER_STEP; i++)
        begin
            trial = {rem_v, num_v[PROD_W-1]};
            num_v = {num_v[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial = trial - {1'b0, dvs_reg};
                rem_v = trial[WIDE_W-1:0];
                quo_v = {quo_v[EST_W-2:0], 1'b1};
            end
            else
            begin
                rem_v = trial[WIDE_W-1:0];
                quo_v = {quo_v[EST_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= dividend[PROD_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_reg  <= divisor[WIDE_W-1] ? (~divisor + 1'b1) : divisor;
            rem_reg  <= '0;
            quo_reg  <= '0;
            neg_reg  <= dividend[PROD_W-1] ^ divisor[WIDE_W-1];
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            num_reg <= num_v;
            rem_reg <= rem_v;
            quo_reg <= quo_v;
            if (cnt_reg == STEP_CNT_W'(STEPS - 1))
            begin
                if (zero_reg)
                    quot_out_reg <= '0;
                else if (neg_reg)
                    quot_out_reg <= ~quo_v + 1'b1;
                else
                    quot_out_reg <= quo_v;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_out_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/adaptive_scalar_kalman_filter_unit.sv
// Top level: adaptive scalar Kalman filter sequencer around a shared multiplier and divider.
//
//  channel   dir  handshake          beat payload
//  samples   in   valid/ready        sample [SAMPLE_BITS-1:0]
//  results   out  valid/ready        filtered [12:0], reloaded
//  cfg_*     in   cfg_wr_en, no wait cfg_index [2:0], cfg_data [23:0]
//
// Each sample runs through the run update, operand setup, a 64-bit product, a 64-bit
// division, a second product and division (each division: start, 32 steps of two bits,
// done) and the final write; the next sample is accepted only once the state is idle.
// Reset is asynchronous, active low; it loads register defaults and clears state.
// A finished result waits in the output register; a stalled sink holds only the
// final write of the next sample, not its acceptance.
`default_nettype none
module adaptive_scalar_kalman_filter_unit #(
    parameter int SCALE_SHIFT = 10,
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    askf_in_if.sink                               samples,
    askf_out_if.source                            results,
    input  wire logic                             cfg_wr_en,
    input  wire logic [askf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [askf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import askf_pkg::*;

    localparam logic signed [EST_W-1:0] ROUND_ADJ = EST_W'((64'd1 << SCALE_SHIFT) - 64'd1);
    localparam int EXT_W = PROD_W - WIDE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RUN,
        S_PREP,
        S_M1GO,
        S_M1WAIT,
        S_D1GO,
        S_D1WAIT,
        S_M2GO,
        S_M2WAIT,
        S_D2GO,
        S_D2WAIT,
        S_FIN
    } state_t;

    state_t state_reg;

    // configuration
    logic [R_W-1:0]     noise_r_steady_reg;
    logic [Q_W-1:0]     noise_q_steady_reg;
    logic [R_W-1:0]     noise_r_fast_reg;
    logic [Q_W-1:0]     noise_q_fast_reg;
    logic [THR_W-1:0]   jump_threshold_reg;
    logic [RUN_W-1:0]   switch_count_reg;
    logic [LIMIT_W-1:0] output_limit_reg;

    // filter state
    logic [EST_W-1:0]   est_reg;
    logic [EST_W-1:0]   cov_reg;
    logic [R_W-1:0]     noise_r_now_reg;
    logic [Q_W-1:0]     noise_q_now_reg;
    logic [RUN_W-1:0]   far_run_reg;
    logic [RUN_W-1:0]   near_run_reg;

    // per-sample work registers
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [WIDE_W-1:0]      p_mid_reg;
    logic [WIDE_W-1:0]      den_reg;
    logic [WIDE_W-1:0]      diff_reg;

    // output register
    logic                  out_valid_reg;
    logic [FILTERED_W-1:0] filtered_reg;
    logic                  reloaded_reg;

    logic [EST_W-1:0]  scaled;
    logic [WIDE_W-1:0] diff_w;
    logic [WIDE_W-1:0] dev_mag;
    logic              is_jump;
    logic [RUN_W-1:0]  far_inc;
    logic [RUN_W-1:0]  near_inc;
    logic [WIDE_W-1:0] p_mid_w;
    logic [WIDE_W-1:0] den_w;
    logic [EST_W-1:0]  res_w;
    logic [EST_W-1:0]  res_reload_w;
    logic              reload_w;
    logic              out_free;

    logic              mul_start;
    logic [PROD_W-1:0] mul_a;
    logic [PROD_W-1:0] mul_b;
    logic              mul_done;
    logic [PROD_W-1:0] mul_product;
    logic              div_start;
    logic              div_done;
    logic [EST_W-1:0]  div_quot;

    // signed divide by 2^SCALE_SHIFT, truncating toward zero
    function automatic logic [EST_W-1:0] div_unit(input logic [EST_W-1:0] x);
        logic signed [EST_W-1:0] adj;
        adj = x[EST_W-1] ? ($signed(x) + ROUND_ADJ) : $signed(x);
        return adj >>> SCALE_SHIFT;
    endfunction

    assign scaled  = EST_W'(sample_reg) << SCALE_SHIFT;
    assign diff_w  = {{(WIDE_W-EST_W){1'b0}}, scaled} - {{(WIDE_W-EST_W){est_reg[EST_W-1]}}, est_reg};
    assign dev_mag = diff_w[WIDE_W-1] ? (~diff_w + 1'b1) : diff_w;
    assign is_jump = dev_mag >= {{(WIDE_W-THR_W){1'b0}}, jump_threshold_reg};
    assign far_inc  = (far_run_reg == '1) ? far_run_reg : far_run_reg + 1'b1;
    assign near_inc = (near_run_reg == '1) ? near_run_reg : near_run_reg + 1'b1;

    assign p_mid_w = {{(WIDE_W-EST_W){cov_reg[EST_W-1]}}, cov_reg}
                   + {{(WIDE_W-Q_W){1'b0}}, noise_q_now_reg};
    assign den_w   = p_mid_w + {{(WIDE_W-R_W){1'b0}}, noise_r_now_reg};

    assign res_w        = div_unit(est_reg);
    assign res_reload_w = div_unit(scaled);
    assign reload_w     = res_w[EST_W-1]
                       || ($signed(res_w) > $signed({{(EST_W-LIMIT_W){1'b0}}, output_limit_reg}));
    assign out_free     = !out_valid_reg || results.ready;

    assign mul_start = (state_reg == S_M1GO) || (state_reg == S_M2GO);
    assign mul_a     = {{EXT_W{p_mid_reg[WIDE_W-1]}}, p_mid_reg};
    assign mul_b     = (state_reg == S_M2GO) ? mul_a : {{EXT_W{diff_reg[WIDE_W-1]}}, diff_reg};
    assign div_start = (state_reg == S_D1GO) || (state_reg == S_D2GO);

    askf_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    askf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // configuration writes; the active noise pair changes only on a run switch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_r_steady_reg <= RST_NOISE_R_STEADY;
            noise_q_steady_reg <= RST_NOISE_Q_STEADY;
            noise_r_fast_reg   <= RST_NOISE_R_FAST;
            noise_q_fast_reg   <= RST_NOISE_Q_FAST;
            jump_threshold_reg <= RST_JUMP_THRESHOLD;
            switch_count_reg   <= RST_SWITCH_COUNT;
            output_limit_reg   <= RST_OUTPUT_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_NOISE_R_STEADY: noise_r_steady_reg <= cfg_data[R_W-1:0];
                REG_NOISE_Q_STEADY: noise_q_steady_reg <= cfg_data[Q_W-1:0];
                REG_NOISE_R_FAST:   noise_r_fast_reg   <= cfg_data[R_W-1:0];
                REG_NOISE_Q_FAST:   noise_q_fast_reg   <= cfg_data[Q_W-1:0];
                REG_JUMP_THRESHOLD: jump_threshold_reg <= cfg_data[THR_W-1:0];
                REG_SWITCH_COUNT:   switch_count_reg   <= cfg_data[RUN_W-1:0];
                REG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            est_reg         <= '0;
            cov_reg         <= '0;
            noise_r_now_reg <= RST_NOISE_R_STEADY;
            noise_q_now_reg <= RST_NOISE_Q_STEADY;
            far_run_reg     <= '0;
            near_run_reg    <= '0;
            out_valid_reg   <= 1'b0;
            sample_reg      <= '0;
            diff_reg        <= '0;
            p_mid_reg       <= '0;
            den_reg         <= '0;
            filtered_reg    <= '0;
            reloaded_reg    <= 1'b0;
        end
        else
        begin
            if (results.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (samples.valid)
                    begin
                        sample_reg <= samples.sample;
                        state_reg  <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    diff_reg <= diff_w;
                    if (is_jump)
                    begin
                        far_run_reg  <= far_inc;
                        near_run_reg <= '0;
                        if (far_inc > switch_count_reg)
                        begin
                            noise_r_now_reg <= noise_r_fast_reg;
                            noise_q_now_reg <= noise_q_fast_reg;
                        end
                    end
                    else
                    begin
                        far_run_reg  <= '0;
                        near_run_reg <= near_inc;
                        if (near_inc > switch_count_reg)
                        begin
                            noise_r_now_reg <= noise_r_steady_reg;
                            noise_q_now_reg <= noise_q_steady_reg;
                        end
                    end
                    state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    p_mid_reg <= p_mid_w;
                    den_reg   <= den_w;
                    state_reg <= S_M1GO;
                end
                S_M1GO:
                    state_reg <= S_M1WAIT;
                S_M1WAIT:
                    if (mul_done)
                        state_reg <= S_D1GO;
                S_D1GO:
                    state_reg <= S_D1WAIT;
                S_D1WAIT:
                begin
                    if (div_done)
                    begin
                        est_reg   <= est_reg + div_quot;
                        state_reg <= S_M2GO;
                    end
                end
                S_M2GO:
                    state_reg <= S_M2WAIT;
                S_M2WAIT:
                    if (mul_done)
                        state_reg <= S_D2GO;
                S_D2GO:
                    state_reg <= S_D2WAIT;
                S_D2WAIT:
                begin
                    if (div_done)
                    begin
                        cov_reg   <= p_mid_reg[EST_W-1:0] - div_quot;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        reloaded_reg  <= reload_w;
                        if (reload_w)
                        begin
                            est_reg      <= scaled;
                            cov_reg      <= scaled;
                            filtered_reg <= res_reload_w[FILTERED_W-1:0];
                        end
                        else
                            filtered_reg <= res_w[FILTERED_W-1:0];
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign samples.ready    = (state_reg == S_IDLE);
    assign results.valid    = out_valid_reg;
    assign results.filtered = filtered_reg;
    assign results.reloaded = reloaded_reg;

endmodule
`default_nettype wire
